/* rtl/gpte_pkg.sv */
// Package with the shared constants, types and helper functions of the grid pixel text embedder.
`default_nettype none
package gpte_pkg;

  // Largest image dimension and depth of the text store.
  localparam int MAX_DIM    = 1024;
  localparam int TEXT_DEPTH = 4096;

  // Widths that follow from the sizes above.
  localparam int CNT_W   = $clog2(MAX_DIM);          // row and column counters
  localparam int DIM_W   = $clog2(MAX_DIM) + 1;      // an effective dimension, 1..MAX_DIM
  localparam int TEXT_AW = $clog2(TEXT_DEPTH);       // text store address
  localparam int TEXT_CW = $clog2(TEXT_DEPTH) + 1;   // byte counts, 0..TEXT_DEPTH

  // Fixed register widths.
  localparam int CFG_DIM_W = 11;
  localparam int CFG_BSEL_W = 2;
  localparam int CFG_LEN_W = 13;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_IDX_W = 3;

  // Mark positions can run one spacing past the last row or column.
  localparam int MARK_W = ((DIM_W > CFG_DIM_W) ? DIM_W : CFG_DIM_W) + 1;

  localparam int BYTE_W = 8;
  localparam int OFF_W  = 3;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 3'd0,
    REG_IMAGE_HEIGHT = 3'd1,
    REG_GRID_SPACING = 3'd2,
    REG_BITS_SELECT  = 3'd3,
    REG_TEXT_LENGTH  = 3'd4
  } cfg_reg_t;

  // Input item kinds carried on tuser.
  localparam logic REQ_TEXT  = 1'b0;
  localparam logic REQ_PIXEL = 1'b1;

  // Pixel held between the mark decision and the embedding stage.
  typedef struct packed {
    logic [BYTE_W-1:0]     pixel;
    logic                  embed;
    logic                  frame_end;
    logic [OFF_W-1:0]      offset;
    logic [CFG_BSEL_W-1:0] bsel;
  } stage_t;

  // Low-bit mask for 1, 2, 4 or 8 hidden bits.
  function automatic logic [BYTE_W-1:0] bit_mask(input logic [CFG_BSEL_W-1:0] bsel);
    logic [BYTE_W-1:0] m;
    case (bsel)
      2'd0:    m = 8'h01;
      2'd1:    m = 8'h03;
      2'd2:    m = 8'h0F;
      default: m = 8'hFF;
    endcase
    return m;
  endfunction

  // Number of hidden bits per marked pixel, as an offset step.
  function automatic logic [OFF_W:0] bit_step(input logic [CFG_BSEL_W-1:0] bsel);
    logic [OFF_W:0] s;
    case (bsel)
      2'd0:    s = 4'd1;
      2'd1:    s = 4'd2;
      2'd2:    s = 4'd4;
      default: s = 4'd8;
    endcase
    return s;
  endfunction

endpackage
`default_nettype wire

/* rtl/gpte_ram.sv */
// Generic single-write, single-read synchronous RAM with a registered read port.
`default_nettype none
module gpte_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

/* rtl/grid_pixel_text_embedder.sv */
// Top level of the grid pixel text embedder: text store, raster counters and embedding stage.
//
// The block hides text in an 8-bit grey image. Text bytes are loaded first (tuser 0, byte in
// tdata[7:0]) and land in a 4096-byte store; loads beyond the store's depth are dropped and
// produce no output transfer. Pixels then stream in raster order (tuser 1, pixel in
// tdata[15:8]), and every pixel gives exactly one output transfer. A pixel whose row and
// column both sit on the grid d-1, 2d-1, ... (d = grid_spacing, 0 acting as 1) has its low b
// bits replaced by (pixel + next b text bits) mod 2^b while fewer than text_length bytes have
// been used; b is 1, 2, 4 or 8 from bits_select, and text bits are taken LSB first. The
// marked row moves on by d only at the end of a marked row. The last pixel of a frame raises
// out_tlast and rewinds the text to its first byte; the loaded text itself stays. Writing
// grid_spacing puts the marks back to d-1. Registers must be written only while no transfer
// is in flight; the block itself does not enforce this, and cfg_ready is always high.
// Throughput is one item per clock while the output is not stalled. A pixel passes stage
// one, which decides the mark and reads the text store through its registered read port,
// then the output register, where the bits are merged. The input side stalls only when
// stage one and the output register both hold a pixel and the output transfer is not taken.
`default_nettype none
module grid_pixel_text_embedder (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Input stream.
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // [7:0] text_byte, [15:8] pixel_in
  input  wire logic        in_tuser,   // [0] req_type
  // Result stream.
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [7:0]  out_tdata,  // [7:0] pixel_out
  output logic             out_tuser,  // [0] embedded
  output logic             out_tlast,  // frame_end
  // Configuration writes.
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [12:0] cfg_data
);

  // Configuration registers.
  logic [gpte_pkg::CFG_DIM_W-1:0]  image_width_r, image_height_r, grid_spacing_r;
  logic [gpte_pkg::CFG_BSEL_W-1:0] bits_select_r;
  logic [gpte_pkg::CFG_LEN_W-1:0]  text_length_r;

  // Raster and text state.
  logic [gpte_pkg::TEXT_CW-1:0] load_ptr_r, load_ptr_nxt;
  logic [gpte_pkg::CNT_W-1:0]   row_r, row_nxt, col_r, col_nxt;
  logic [gpte_pkg::MARK_W-1:0]  mark_row_r, mark_row_nxt, mark_col_r, mark_col_nxt;
  logic [gpte_pkg::TEXT_CW-1:0] byte_idx_r, byte_idx_nxt;
  logic [gpte_pkg::OFF_W-1:0]   bit_off_r, bit_off_nxt;

  // Pipeline registers.
  logic              s1_valid_r, s1_valid_nxt;
  gpte_pkg::stage_t  s1_r, s1_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [7:0]        out_pixel_r, out_pixel_nxt;
  logic              out_emb_r, out_emb_nxt;
  logic              out_fend_r, out_fend_nxt;

  // Handshake terms.
  logic in_fire, cfg_fire, s1_move, text_fire, pixel_fire;

  // Effective settings.
  logic [gpte_pkg::DIM_W-1:0]   eff_w, eff_h;
  logic [gpte_pkg::CFG_DIM_W-1:0] spacing, spacing_m1;
  logic [gpte_pkg::TEXT_CW-1:0] limit;

  // Mark decision terms.
  logic                        hit;
  logic [gpte_pkg::OFF_W:0]    off_sum;
  logic [gpte_pkg::MARK_W-1:0] col_mark_adv;
  logic                        row_end, frame_last;

  // Text store ports.
  logic                         ram_we, ram_re;
  logic [gpte_pkg::TEXT_AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]                   ram_rdata;

  // Embedding terms.
  logic [7:0] mask, text_bits, pix_sum, merged;

  assign s1_move   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_move;
  assign in_fire   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid;

  assign text_fire  = in_fire && (in_tuser == gpte_pkg::REQ_TEXT);
  assign pixel_fire = in_fire && (in_tuser == gpte_pkg::REQ_PIXEL);

  // Zero acts as one; a dimension above the largest acts as the largest; text length caps at the depth.
  always_comb begin
    if (image_width_r == '0) begin
      eff_w = gpte_pkg::DIM_W'(1);
    end else if (32'(image_width_r) > gpte_pkg::MAX_DIM) begin
      eff_w = gpte_pkg::DIM_W'(gpte_pkg::MAX_DIM);
    end else begin
      eff_w = gpte_pkg::DIM_W'(image_width_r);
    end
    if (image_height_r == '0) begin
      eff_h = gpte_pkg::DIM_W'(1);
    end else if (32'(image_height_r) > gpte_pkg::MAX_DIM) begin
      eff_h = gpte_pkg::DIM_W'(gpte_pkg::MAX_DIM);
    end else begin
      eff_h = gpte_pkg::DIM_W'(image_height_r);
    end
    if (32'(text_length_r) > gpte_pkg::TEXT_DEPTH) begin
      limit = gpte_pkg::TEXT_CW'(gpte_pkg::TEXT_DEPTH);
    end else begin
      limit = gpte_pkg::TEXT_CW'(text_length_r);
    end
  end

  assign spacing    = (grid_spacing_r == '0) ? gpte_pkg::CFG_DIM_W'(1) : grid_spacing_r;
  assign spacing_m1 = spacing - gpte_pkg::CFG_DIM_W'(1);

  // A pixel is marked when it sits on both marks and text remains.
  assign hit = (gpte_pkg::MARK_W'(row_r) == mark_row_r) &&
               (gpte_pkg::MARK_W'(col_r) == mark_col_r) &&
               (byte_idx_r < limit);

  assign off_sum      = {1'b0, bit_off_r} + gpte_pkg::bit_step(bits_select_r);
  assign col_mark_adv = hit ? (mark_col_r + gpte_pkg::MARK_W'(spacing)) : mark_col_r;
  assign row_end      = (gpte_pkg::DIM_W'(col_r) >= eff_w - gpte_pkg::DIM_W'(1));
  assign frame_last   = (gpte_pkg::DIM_W'(row_r) >= eff_h - gpte_pkg::DIM_W'(1));

  // The store is read at the current byte for every pixel, so the byte for a marked pixel
  // is in the read register when that pixel reaches the embedding stage. A byte that moves
  // on after a marked pixel is read again by the very next pixel.
  assign ram_we    = text_fire && !load_ptr_r[gpte_pkg::TEXT_CW-1];
  assign ram_waddr = load_ptr_r[gpte_pkg::TEXT_AW-1:0];
  assign ram_re    = pixel_fire;
  assign ram_raddr = byte_idx_r[gpte_pkg::TEXT_AW-1:0];

  gpte_ram #(
    .WIDTH (8),
    .DEPTH (gpte_pkg::TEXT_DEPTH)
  ) u_text_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_tdata[7:0]),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Raster counters, marks and the text cursor.
  always_comb begin
    load_ptr_nxt = load_ptr_r;
    row_nxt      = row_r;
    col_nxt      = col_r;
    mark_row_nxt = mark_row_r;
    mark_col_nxt = mark_col_r;
    byte_idx_nxt = byte_idx_r;
    bit_off_nxt  = bit_off_r;

    if (ram_we) begin
      load_ptr_nxt = load_ptr_r + gpte_pkg::TEXT_CW'(1);
    end

    if (pixel_fire) begin
      if (hit) begin
        if (off_sum[gpte_pkg::OFF_W]) begin
          bit_off_nxt  = '0;
          byte_idx_nxt = byte_idx_r + gpte_pkg::TEXT_CW'(1);
        end else begin
          bit_off_nxt = off_sum[gpte_pkg::OFF_W-1:0];
        end
      end
      // Column mark returns to the first grid column once it runs past the row.
      if (col_mark_adv >= gpte_pkg::MARK_W'(eff_w)) begin
        mark_col_nxt = gpte_pkg::MARK_W'(spacing_m1);
      end else begin
        mark_col_nxt = col_mark_adv;
      end
      if (row_end) begin
        col_nxt = '0;
        if (gpte_pkg::MARK_W'(row_r) == mark_row_r) begin
          mark_row_nxt = mark_row_r + gpte_pkg::MARK_W'(spacing);
        end
        if (frame_last) begin
          row_nxt      = '0;
          byte_idx_nxt = '0;
          bit_off_nxt  = '0;
          mark_row_nxt = gpte_pkg::MARK_W'(spacing_m1);
          mark_col_nxt = gpte_pkg::MARK_W'(spacing_m1);
        end else begin
          row_nxt = row_r + gpte_pkg::CNT_W'(1);
        end
      end else begin
        col_nxt = col_r + gpte_pkg::CNT_W'(1);
      end
    end

    // A new spacing puts both marks back on the first grid point.
    if (cfg_fire && (cfg_index == gpte_pkg::REG_GRID_SPACING)) begin
      mark_row_nxt = gpte_pkg::MARK_W'(cfg_data[gpte_pkg::CFG_DIM_W-1:0]
                     - gpte_pkg::CFG_DIM_W'(1));
      mark_col_nxt = mark_row_nxt;
      if (cfg_data[gpte_pkg::CFG_DIM_W-1:0] == '0) begin
        mark_row_nxt = '0;
        mark_col_nxt = '0;
      end
    end
  end

  // Stage one holds the pixel while the store read completes.
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    s1_nxt       = s1_r;
    if (pixel_fire) begin
      s1_valid_nxt     = 1'b1;
      s1_nxt.pixel     = in_tdata[15:8];
      s1_nxt.embed     = hit;
      s1_nxt.frame_end = row_end && frame_last;
      s1_nxt.offset    = bit_off_r;
      s1_nxt.bsel      = bits_select_r;
    end else if (s1_move) begin
      s1_valid_nxt = 1'b0;
    end
  end

  // Embedding: low bits become (pixel + text bits) modulo 2^b.
  assign mask      = gpte_pkg::bit_mask(s1_r.bsel);
  assign text_bits = (ram_rdata >> s1_r.offset) & mask;
  assign pix_sum   = s1_r.pixel + text_bits;
  assign merged    = s1_r.embed ? ((s1_r.pixel & ~mask) | (pix_sum & mask)) : s1_r.pixel;

  always_comb begin
    out_valid_nxt = s1_move || (out_valid_r && !out_tready);
    out_pixel_nxt = out_pixel_r;
    out_emb_nxt   = out_emb_r;
    out_fend_nxt  = out_fend_r;
    if (s1_move) begin
      out_pixel_nxt = merged;
      out_emb_nxt   = s1_r.embed;
      out_fend_nxt  = s1_r.frame_end;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r  <= gpte_pkg::CFG_DIM_W'(1024);
      image_height_r <= gpte_pkg::CFG_DIM_W'(1024);
      grid_spacing_r <= gpte_pkg::CFG_DIM_W'(1);
      bits_select_r  <= '0;
      text_length_r  <= '0;
      load_ptr_r     <= '0;
      row_r          <= '0;
      col_r          <= '0;
      mark_row_r     <= '0;
      mark_col_r     <= '0;
      byte_idx_r     <= '0;
      bit_off_r      <= '0;
      s1_valid_r     <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_fire) begin
        unique case (cfg_index)
          gpte_pkg::REG_IMAGE_WIDTH:  image_width_r  <= cfg_data[gpte_pkg::CFG_DIM_W-1:0];
          gpte_pkg::REG_IMAGE_HEIGHT: image_height_r <= cfg_data[gpte_pkg::CFG_DIM_W-1:0];
          gpte_pkg::REG_GRID_SPACING: grid_spacing_r <= cfg_data[gpte_pkg::CFG_DIM_W-1:0];
          gpte_pkg::REG_BITS_SELECT:  bits_select_r  <= cfg_data[gpte_pkg::CFG_BSEL_W-1:0];
          gpte_pkg::REG_TEXT_LENGTH:  text_length_r  <= cfg_data[gpte_pkg::CFG_LEN_W-1:0];
          default: ;
        endcase
      end
      load_ptr_r  <= load_ptr_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      mark_row_r  <= mark_row_nxt;
      mark_col_r  <= mark_col_nxt;
      byte_idx_r  <= byte_idx_nxt;
      bit_off_r   <= bit_off_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    s1_r        <= s1_nxt;
    out_pixel_r <= out_pixel_nxt;
    out_emb_r   <= out_emb_nxt;
    out_fend_r  <= out_fend_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_pixel_r;
  assign out_tuser  = out_emb_r;
  assign out_tlast  = out_fend_r;

endmodule
`default_nettype wire

/* tb/sv/grid_pixel_text_embedder_tb.sv */
// Self-checking testbench for the grid pixel text embedder: stimulus, predictor and result checks.
`default_nettype none
module grid_pixel_text_embedder_tb;

  // Half clock period, the drain time after the last result, the random item budget and the hard stop.
  localparam int CLK_HALF       = 10;
  localparam int SETTLE_CYCLES  = 6;
  localparam int RANDOM_ITEMS   = 700;
  localparam int TIMEOUT_CYCLES = 1_000_000;

  // One predicted output transfer.
  typedef struct {
    logic [gpte_pkg::BYTE_W-1:0] pixel;
    logic                        embedded;
    logic                        frame_end;
  } pixel_result_t;

  // The scoreboard keeps its own copy of the registers, the text store and the raster
  // position. Every accepted pixel yields one predicted result; text loads yield none.
  class embed_checker;
    logic [gpte_pkg::BYTE_W-1:0]     text_mem [gpte_pkg::TEXT_DEPTH];
    logic [gpte_pkg::TEXT_CW-1:0]    load_ptr;
    logic [gpte_pkg::CFG_DIM_W-1:0]  width_reg, height_reg, spacing_reg;
    logic [gpte_pkg::CFG_BSEL_W-1:0] bsel_reg;
    logic [gpte_pkg::CFG_LEN_W-1:0]  length_reg;
    logic [gpte_pkg::CNT_W-1:0]      row, col;
    logic [gpte_pkg::MARK_W-1:0]     mark_row, mark_col;
    logic [gpte_pkg::TEXT_CW-1:0]    byte_idx;
    logic [gpte_pkg::OFF_W:0]        bit_off;
    pixel_result_t                   expected_pixels[$];
    int                              errors;

    function new();
      load_ptr    = '0;
      width_reg   = gpte_pkg::CFG_DIM_W'(gpte_pkg::MAX_DIM);
      height_reg  = gpte_pkg::CFG_DIM_W'(gpte_pkg::MAX_DIM);
      spacing_reg = gpte_pkg::CFG_DIM_W'(1);
      bsel_reg    = '0;
      length_reg  = '0;
      row         = '0;
      col         = '0;
      byte_idx    = '0;
      bit_off     = '0;
      errors      = 0;
      reload_marks();
    endfunction

    // A spacing of zero behaves as one.
    function logic [gpte_pkg::CFG_DIM_W-1:0] grid_step();
      return (spacing_reg == '0) ? gpte_pkg::CFG_DIM_W'(1) : spacing_reg;
    endfunction

    // Width and height of zero act as one; values past MAX_DIM act as MAX_DIM.
    function logic [gpte_pkg::DIM_W-1:0] clamp_dim(logic [gpte_pkg::CFG_DIM_W-1:0] v);
      if (v == '0) return gpte_pkg::DIM_W'(1);
      if (v > gpte_pkg::MAX_DIM) return gpte_pkg::DIM_W'(gpte_pkg::MAX_DIM);
      return gpte_pkg::DIM_W'(v);
    endfunction

    function void reload_marks();
      mark_row = gpte_pkg::MARK_W'(grid_step() - 1);
      mark_col = gpte_pkg::MARK_W'(grid_step() - 1);
    endfunction

    function void write_reg(gpte_pkg::cfg_reg_t idx, logic [gpte_pkg::CFG_DATA_W-1:0] val);
      case (idx)
        gpte_pkg::REG_IMAGE_WIDTH:  width_reg = val[gpte_pkg::CFG_DIM_W-1:0];
        gpte_pkg::REG_IMAGE_HEIGHT: height_reg = val[gpte_pkg::CFG_DIM_W-1:0];
        gpte_pkg::REG_GRID_SPACING: begin
          spacing_reg = val[gpte_pkg::CFG_DIM_W-1:0];
          reload_marks();
        end
        gpte_pkg::REG_BITS_SELECT:  bsel_reg = val[gpte_pkg::CFG_BSEL_W-1:0];
        gpte_pkg::REG_TEXT_LENGTH:  length_reg = val[gpte_pkg::CFG_LEN_W-1:0];
        default: ;
      endcase
    endfunction

    // Works out the output for one pixel and moves the raster position on.
    function pixel_result_t embed_pixel(logic [gpte_pkg::BYTE_W-1:0] pix);
      logic [gpte_pkg::DIM_W-1:0]     w, h;
      logic [gpte_pkg::CFG_DIM_W-1:0] d;
      logic [gpte_pkg::TEXT_CW-1:0]   limit;
      logic [gpte_pkg::OFF_W:0]       nbits;
      logic [gpte_pkg::BYTE_W-1:0]    mask, hidden;
      pixel_result_t                  r;
      w     = clamp_dim(width_reg);
      h     = clamp_dim(height_reg);
      d     = grid_step();
      limit = (length_reg > gpte_pkg::TEXT_DEPTH) ? gpte_pkg::TEXT_CW'(gpte_pkg::TEXT_DEPTH)
                                                  : gpte_pkg::TEXT_CW'(length_reg);
      r.pixel     = pix;
      r.embedded  = 1'b0;
      r.frame_end = 1'b0;
      if (row == mark_row && col == mark_col && byte_idx < limit) begin
        nbits  = (gpte_pkg::OFF_W+1)'(1) << bsel_reg;
        mask   = gpte_pkg::BYTE_W'((9'd1 << nbits) - 9'd1);
        // Bits above bit 7 of the byte shift in as zeros.
        hidden = (text_mem[byte_idx[gpte_pkg::TEXT_AW-1:0]] >> bit_off[gpte_pkg::OFF_W-1:0])
                 & mask;
        r.pixel    = (pix & ~mask) | (gpte_pkg::BYTE_W'(pix + hidden) & mask);
        r.embedded = 1'b1;
        bit_off = bit_off + nbits;
        if (bit_off >= 8) begin
          bit_off  = '0;
          byte_idx = byte_idx + 1'b1;
        end
        mark_col = mark_col + d;
      end
      if (mark_col >= w) mark_col = gpte_pkg::MARK_W'(d - 1);
      if (col >= w - 1) begin
        if (row == mark_row) mark_row = mark_row + d;
        col = '0;
        if (row >= h - 1) begin
          r.frame_end = 1'b1;
          row      = '0;
          byte_idx = '0;
          bit_off  = '0;
          reload_marks();
        end else begin
          row = row + 1'b1;
        end
      end else begin
        col = col + 1'b1;
      end
      return r;
    endfunction

    function void take_input(logic req, logic [gpte_pkg::BYTE_W-1:0] text_byte,
                             logic [gpte_pkg::BYTE_W-1:0] pix);
      if (req == gpte_pkg::REQ_TEXT) begin
        // Loads past the depth of the store are dropped.
        if (load_ptr < gpte_pkg::TEXT_DEPTH) begin
          text_mem[load_ptr[gpte_pkg::TEXT_AW-1:0]] = text_byte;
          load_ptr = load_ptr + 1'b1;
        end
      end else begin
        expected_pixels.push_back(embed_pixel(pix));
      end
    endfunction

    function void take_result(logic [gpte_pkg::BYTE_W-1:0] pix, logic emb, logic fend);
      pixel_result_t want;
      if (expected_pixels.size() == 0) begin
        $error("unexpected result: pixel_out %02h embedded %0b frame_end %0b", pix, emb, fend);
        errors++;
        return;
      end
      want = expected_pixels.pop_front();
      if (pix !== want.pixel) begin
        $error("pixel_out: expected %02h, actual %02h", want.pixel, pix);
        errors++;
      end
      if (emb !== want.embedded) begin
        $error("embedded: expected %0b, actual %0b", want.embedded, emb);
        errors++;
      end
      if (fend !== want.frame_end) begin
        $error("frame_end: expected %0b, actual %0b", want.frame_end, fend);
        errors++;
      end
    endfunction
  endclass

  // Every input of the block starts at a known value.
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;   // [7:0] text_byte, [15:8] pixel_in
  logic        in_tuser = 1'b0; // [0] req_type
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;       // [7:0] pixel_out
  logic        out_tuser;       // [0] embedded
  logic        out_tlast;       // frame_end
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [12:0] cfg_data = '0;

  embed_checker board;

  // Sender pacing: bursts of random length with random gaps, or no gaps at all in a
  // steady phase.
  int burst_left = 0;
  bit steady = 1'b0;
  int random_items = 0;

  // Receiver stall pattern state.
  int       stall_left = 0;
  int       stall_mode = 0;
  bit [7:0] stall_pattern = 8'hFF;

  grid_pixel_text_embedder dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // The receiver switches between always ready, random stalls and a rotating 8-bit pattern,
  // taking a new mode and pattern each time its countdown runs out. The pattern always
  // holds at least one ready bit.
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode    = $urandom_range(0, 2);
      stall_pattern = 8'($urandom) | 8'h01;
      stall_left    = $urandom_range(16, 96);
    end else begin
      stall_left = stall_left - 1;
    end
    case (stall_mode)
      0:       out_tready <= 1'b1;
      1:       out_tready <= ($urandom_range(0, 3) != 0);
      default: out_tready <= stall_pattern[stall_left[2:0]];
    endcase
  end

  // Every output transfer is checked against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) board.take_result(out_tdata, out_tuser, out_tlast);
  end

  // Hard stop in case the block hangs.
  initial begin
    #(2 * CLK_HALF * TIMEOUT_CYCLES);
    $display("grid_pixel_text_embedder_tb: done, errors");
    $finish;
  end

  task automatic idle_input(int n);
    repeat (n) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
  endtask

  // Drives one input item and waits for its transfer. A new burst may open with a random gap.
  task automatic send_item(logic req, logic [7:0] text_byte, logic [7:0] pix);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      idle_input(steady ? 0 : $urandom_range(0, 6));
    end
    burst_left--;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= {pix, text_byte};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    board.take_input(req, text_byte, pix);
  endtask

  // The unused half of tdata carries random bits as well.
  task automatic send_pixel(logic [7:0] pix);
    send_item(gpte_pkg::REQ_PIXEL, 8'($urandom), pix);
  endtask

  task automatic send_text(logic [7:0] text_byte);
    send_item(gpte_pkg::REQ_TEXT, text_byte, 8'($urandom));
  endtask

  // Holds the sender off until every predicted result has come back.
  task automatic wait_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (board.expected_pixels.size() != 0) @(posedge clk);
  endtask

  // A text load gives no result, so a drain time passes after the last result before
  // the block counts as idle.
  task automatic settle();
    wait_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(gpte_pkg::cfg_reg_t idx, logic [gpte_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.write_reg(idx, val);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_frame(int w, int h, int d, int bsel, int len);
    write_reg(gpte_pkg::REG_IMAGE_WIDTH, gpte_pkg::CFG_DATA_W'(w));
    write_reg(gpte_pkg::REG_IMAGE_HEIGHT, gpte_pkg::CFG_DATA_W'(h));
    write_reg(gpte_pkg::REG_GRID_SPACING, gpte_pkg::CFG_DATA_W'(d));
    write_reg(gpte_pkg::REG_BITS_SELECT, gpte_pkg::CFG_DATA_W'(bsel));
    write_reg(gpte_pkg::REG_TEXT_LENGTH, gpte_pkg::CFG_DATA_W'(len));
  endtask

  // Mostly small sizes keep frames short; the extremes and out-of-range values come now
  // and then.
  function automatic logic [gpte_pkg::CFG_DATA_W-1:0] pick_dim();
    case ($urandom_range(0, 15))
      0:       return gpte_pkg::CFG_DATA_W'(0);
      1:       return gpte_pkg::CFG_DATA_W'(1);
      2:       return gpte_pkg::CFG_DATA_W'(gpte_pkg::MAX_DIM);
      3:       return gpte_pkg::CFG_DATA_W'(2047);
      4:       return gpte_pkg::CFG_DATA_W'($urandom_range(gpte_pkg::MAX_DIM + 1, 2047));
      5:       return gpte_pkg::CFG_DATA_W'($urandom_range(1, gpte_pkg::MAX_DIM));
      default: return gpte_pkg::CFG_DATA_W'($urandom_range(1, 10));
    endcase
  endfunction

  function automatic logic [gpte_pkg::CFG_DATA_W-1:0] pick_spacing();
    case ($urandom_range(0, 11))
      0:       return gpte_pkg::CFG_DATA_W'(0);
      1:       return gpte_pkg::CFG_DATA_W'(gpte_pkg::MAX_DIM);
      2:       return gpte_pkg::CFG_DATA_W'(2047);
      3:       return gpte_pkg::CFG_DATA_W'($urandom_range(5, 2047));
      default: return gpte_pkg::CFG_DATA_W'($urandom_range(1, 4));
    endcase
  endfunction

  // The text length never reaches past the bytes loaded so far, so the block never reads
  // a store entry that was not written.
  function automatic logic [gpte_pkg::CFG_DATA_W-1:0] pick_length();
    logic [gpte_pkg::TEXT_CW-1:0] stored;
    stored = board.load_ptr;
    if (stored >= gpte_pkg::TEXT_DEPTH) return gpte_pkg::CFG_DATA_W'($urandom_range(0, 8191));
    case ($urandom_range(0, 3))
      0:       return gpte_pkg::CFG_DATA_W'(stored);
      1:       return gpte_pkg::CFG_DATA_W'(0);
      default: return gpte_pkg::CFG_DATA_W'($urandom_range(0, stored));
    endcase
  endfunction

  initial begin
    int n;
    board = new();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part. Two pixels under the reset settings embed nothing because the text
    // length is zero.
    send_pixel(8'h00);
    send_pixel(8'hFF);
    send_text(8'h00);
    send_text(8'hFF);
    send_text(8'hA5);
    send_text(8'h3C);
    send_text(8'h80);
    send_text(8'h01);
    settle();

    // Spacing one, and every marked pixel takes a whole byte. The raster is part way along the
    // first row, which ends early with no marked pixel; every pixel after it is marked.
    set_frame(4, 2, 1, 3, 6);
    send_pixel(8'h00);
    send_pixel(8'hFF);
    send_pixel(8'hFF);
    send_pixel(8'h00);
    send_pixel(8'h80);
    send_pixel(8'h01);
    send_pixel(8'hFE);
    send_pixel(8'h7F);
    settle();

    // Spacing two in a 3x3 frame marks only the center pixel, with four bits each.
    set_frame(3, 3, 2, 2, 6);
    repeat (9) send_pixel(8'($urandom));
    settle();

    // Random part. Each phase loads a little text, reprograms some registers, then
    // streams pixels with stray text loads mixed in. Registers that are not rewritten
    // keep their value, so mark positions and the bit offset run on across phases.
    while (random_items < RANDOM_ITEMS) begin
      steady = ($urandom_range(0, 3) == 0);
      n = $urandom_range(0, 12);
      repeat (n) send_text(8'($urandom));
      random_items += n;
      settle();
      if ($urandom_range(0, 1)) write_reg(gpte_pkg::REG_IMAGE_WIDTH, pick_dim());
      if ($urandom_range(0, 1)) write_reg(gpte_pkg::REG_IMAGE_HEIGHT, pick_dim());
      if ($urandom_range(0, 2) == 0) write_reg(gpte_pkg::REG_GRID_SPACING, pick_spacing());
      if ($urandom_range(0, 1)) begin
        write_reg(gpte_pkg::REG_BITS_SELECT, gpte_pkg::CFG_DATA_W'($urandom_range(0, 3)));
      end
      if ($urandom_range(0, 1)) write_reg(gpte_pkg::REG_TEXT_LENGTH, pick_length());
      n = $urandom_range(10, 120);
      repeat (n) begin
        if ($urandom_range(0, 7) == 0) send_text(8'($urandom));
        else send_pixel(8'($urandom));
        if ($urandom_range(0, 199) == 0) wait_results();
      end
      random_items += n;
    end
    steady = 1'b0;
    settle();

    // A 1x1 frame ends on every pixel, which brings the raster back to its origin. The
    // second pixel then takes the first byte with the text length clamped to the store
    // depth.
    set_frame(1, 1, 1, 3, 0);
    send_pixel(8'($urandom));
    settle();
    write_reg(gpte_pkg::REG_TEXT_LENGTH, gpte_pkg::CFG_DATA_W'(8191));
    send_pixel(8'($urandom));
    settle();

    set_frame(5, 4, 2, 0, gpte_pkg::TEXT_DEPTH);
    repeat (30) send_pixel(8'($urandom));

    settle();
    if (board.errors == 0 && board.expected_pixels.size() == 0) begin
      $display("grid_pixel_text_embedder_tb: done, clean");
    end else begin
      $display("grid_pixel_text_embedder_tb: done, errors");
    end
    $finish;
  end

endmodule
`default_nettype wire
